@@ design/pfta_pkg.sv @@
// Shared types and constants of the planar face texel address unit.
package pfta_pkg;

  localparam int WORD_W     = 32;
  localparam int FACE_WORDS = 15;

  // Cells after scaling are saturated to +-2^40 and fit in 42 signed bits.
  localparam int CELL_SAT_BITS = 40;
  localparam int CELL_W        = 42;
  localparam int DIFF_W        = CELL_W + 1;
  localparam int COL_W         = 31;

  localparam logic [31:0] INV_SPACING_RESET = 32'd65536;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ATLAS_W     = 2'd0,
    REG_ATLAS_H     = 2'd1,
    REG_INV_SPACING = 2'd2
  } reg_idx_t;

  // Word positions inside one face record.
  localparam logic [3:0] WI_ORG_X   = 4'd0;
  localparam logic [3:0] WI_ORG_Y   = 4'd1;
  localparam logic [3:0] WI_ORG_Z   = 4'd2;
  localparam logic [3:0] WI_U_X     = 4'd3;
  localparam logic [3:0] WI_U_Y     = 4'd4;
  localparam logic [3:0] WI_U_Z     = 4'd5;
  localparam logic [3:0] WI_U_START = 4'd6;
  localparam logic [3:0] WI_V_X     = 4'd7;
  localparam logic [3:0] WI_V_Y     = 4'd8;
  localparam logic [3:0] WI_V_Z     = 4'd9;
  localparam logic [3:0] WI_V_START = 4'd10;
  localparam logic [3:0] WI_TILE_X  = 4'd11;
  localparam logic [3:0] WI_TILE_Y  = 4'd12;
  localparam logic [3:0] WI_TILE_W  = 4'd13;
  localparam logic [3:0] WI_TILE_H  = 4'd14;

  // One write into the face table.
  typedef struct packed {
    logic              en;
    logic [3:0]        word;
    logic [WORD_W-1:0] data;
  } tbl_wr_t;

  // Record fields that ride along the pipeline next to the arithmetic.
  typedef struct packed {
    logic               bad;
    logic signed [31:0] start_u;
    logic signed [31:0] start_v;
    logic signed [31:0] tile_x;
    logic signed [31:0] tile_y;
    logic signed [31:0] tile_w;
    logic signed [31:0] tile_h;
  } side_t;

endpackage

@@ design/pfta_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pfta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/pfta_face_store.sv @@
// Face table: one RAM per record word, with a clearing pass after reset.
module pfta_face_store import pfta_pkg::*; #(
  parameter int FACE_COUNT = 1024,
  parameter int ADDR_W     = (FACE_COUNT > 1) ? $clog2(FACE_COUNT) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tbl_wr_t                           wr,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic                              rd_en,
  input  logic [ADDR_W-1:0]                 rd_addr,
  output logic [FACE_WORDS-1:0][WORD_W-1:0] rec,
  output logic                              clearing
);

  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;

  // The pass zeroes one record per cycle, all words at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(FACE_COUNT - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  assign waddr = clearing ? clr_addr : wr_addr;
  assign wdata = clearing ? '0 : wr.data;

  for (genvar gi = 0; gi < FACE_WORDS; gi++) begin : g_word
    logic we;
    assign we = clearing || (wr.en && (wr.word == 4'(gi)));

    pfta_ram #(
      .WIDTH (WORD_W),
      .DEPTH (FACE_COUNT)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rec[gi])
    );
  end

endmodule

@@ design/pfta_dot.sv @@
// Three-term dot product of a relative point with one face axis, floored to the fraction.
module pfta_dot #(
  parameter int FRAC_BITS = 16,
  parameter int SUM_W     = 66 - FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    en_prod,
  input  logic                    en_sum,
  input  logic signed [32:0]      rel  [3],
  input  logic signed [31:0]      axis [3],
  output logic signed [SUM_W-1:0] sum
);

  localparam int PROD_W = 65;
  localparam int TERM_W = PROD_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod [3];
  logic signed [TERM_W-1:0] term [3];

  always_ff @(posedge clk) begin
    if (en_prod) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= rel[i] * axis[i];
      end
    end
  end

  // An arithmetic shift is the floor toward minus infinity.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      term[i] = TERM_W'(prod[i] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum <= SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2]);
    end
  end

endmodule

@@ design/pfta_scale.sv @@
// Scales a coordinate by the inverse spacing, floors it and saturates the cell.
module pfta_scale import pfta_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int U_W       = 66 - FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     en_mul,
  input  logic                     en_sat,
  input  logic signed [U_W-1:0]    u,
  input  logic [31:0]              inv,
  output logic signed [CELL_W-1:0] cell_pos
);

  localparam int HI_W  = U_W - 32;
  localparam int P_W   = U_W + 32;
  localparam int SHIFT = 2 * FRAC_BITS;
  localparam logic signed [P_W-1:0] SAT_HI = P_W'(64'sd1) <<< CELL_SAT_BITS;
  localparam logic signed [P_W-1:0] SAT_LO = -SAT_HI;

  logic signed [HI_W-1:0]  u_hi;
  logic signed [32:0]      inv_s;
  logic [63:0]             lo_p;
  logic signed [HI_W+32:0] hi_p;
  logic signed [P_W-1:0]   full;
  logic signed [P_W-1:0]   q;
  logic signed [CELL_W-1:0] cell_pos_next;

  assign u_hi  = u[U_W-1:32];
  assign inv_s = {1'b0, inv};

  // Two partial products: the low 32 bits unsigned, the upper bits signed.
  always_ff @(posedge clk) begin
    if (en_mul) begin
      lo_p <= 64'(u[31:0]) * 64'(inv);
      hi_p <= u_hi * inv_s;
    end
  end

  always_comb begin
    full = (P_W'(hi_p) <<< 32) + P_W'($signed({1'b0, lo_p}));
    q    = full >>> SHIFT;
    if (q > SAT_HI) begin
      cell_pos_next = CELL_W'(SAT_HI);
    end else if (q < SAT_LO) begin
      cell_pos_next = CELL_W'(SAT_LO);
    end else begin
      cell_pos_next = CELL_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en_sat) begin
      cell_pos <= cell_pos_next;
    end
  end

endmodule

@@ design/planar_face_texel_address_unit.sv @@
// Planar face texel address unit: maps 3-D query points to texels of a shared atlas.
//
// Load words (command 0) write one 32-bit word of one face record straight into the
// face table at acceptance and produce no result; query words (command 1) take a face
// number and a Q16.16 point and produce exactly one result word, in order. The block
// accepts one word per cycle while in_ready is high, and each query passes through
// the nine-stage datapath (table read, origin subtract, axis products, floored sums,
// split scale multiply, saturation, start subtract and clamp, tile offset and range
// check, row-major address multiply). Each stage holds its own valid bit and only
// stalls when the stage after it is full and cannot move, so bubbles are squeezed
// out and a waiting result stops new words entering only once every stage holds a
// query. After reset the face table is zeroed by a clearing pass over all FACE_COUNT
// records, one record per cycle, during which in_ready is low; configuration writes
// are taken at any time but must only be issued while no query is in flight.
module planar_face_texel_address_unit import pfta_pkg::*; #(
  parameter int FACE_COUNT = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [9:0]         face_index,
  input  logic [3:0]         word_index,
  input  logic signed [31:0] word_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  // Output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [31:0]        texel_index
);

  localparam int ADDR_W = (FACE_COUNT > 1) ? $clog2(FACE_COUNT) : 1;
  localparam int U_W    = 66 - FRAC_BITS;
  localparam int NSTAGE = 9;

  // Configuration registers.
  logic [15:0] atlas_width;
  logic [15:0] atlas_height;
  logic [31:0] inv_spacing;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= '0;
      atlas_height <= '0;
      inv_spacing  <= INV_SPACING_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_ATLAS_W:     atlas_width  <= cfg_wdata[15:0];
        REG_ATLAS_H:     atlas_height <= cfg_wdata[15:0];
        REG_INV_SPACING: inv_spacing  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Pipeline control. A stage may load when it is empty or when the stage after it
  // is loading too; the output register is the last stage.
  logic [NSTAGE:1]   v;
  logic [NSTAGE+1:1] rdy;

  assign rdy[NSTAGE+1] = out_ready;
  for (genvar gk = 1; gk <= NSTAGE; gk++) begin : g_rdy
    assign rdy[gk] = !v[gk] || rdy[gk+1];
  end

  logic clearing;
  logic in_acc;
  logic query_acc;
  logic face_ok;

  assign in_ready  = rdy[1] && !clearing;
  assign in_acc    = in_valid && in_ready;
  assign query_acc = in_acc && (command == CMD_QUERY);
  assign face_ok   = {22'd0, face_index} < 32'(FACE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= query_acc;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Face table. Loads to a face beyond the table are dropped here; a word index past
  // the record matches no RAM and is dropped inside the store.
  tbl_wr_t                           tbl_wr;
  logic [FACE_WORDS-1:0][WORD_W-1:0] rec1;

  assign tbl_wr.en   = in_acc && (command == CMD_LOAD) && face_ok;
  assign tbl_wr.word = word_index;
  assign tbl_wr.data = word_value;

  pfta_face_store #(
    .FACE_COUNT (FACE_COUNT),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (tbl_wr),
    .wr_addr  (ADDR_W'(face_index)),
    .rd_en    (query_acc),
    .rd_addr  (ADDR_W'(face_index)),
    .rec      (rec1),
    .clearing (clearing)
  );

  // Stage 1: the point and the face check wait beside the table read.
  logic signed [31:0] p1_x;
  logic signed [31:0] p1_y;
  logic signed [31:0] p1_z;
  logic               face_ok1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p1_x     <= point_x;
      p1_y     <= point_y;
      p1_z     <= point_z;
      face_ok1 <= face_ok;
    end
  end

  // Stage 2: point minus origin, exact in 33 bits, plus the record fields needed later.
  // An empty tile or a face beyond the table marks the query as not found.
  logic signed [32:0] rel2 [3];
  logic signed [31:0] axu2 [3];
  logic signed [31:0] axv2 [3];
  side_t              side_in;
  side_t              side [2:7];

  always_comb begin
    side_in.bad     = !face_ok1 ||
                      ($signed(rec1[WI_TILE_W]) <= 32'sd0) ||
                      ($signed(rec1[WI_TILE_H]) <= 32'sd0);
    side_in.start_u = $signed(rec1[WI_U_START]);
    side_in.start_v = $signed(rec1[WI_V_START]);
    side_in.tile_x  = $signed(rec1[WI_TILE_X]);
    side_in.tile_y  = $signed(rec1[WI_TILE_Y]);
    side_in.tile_w  = $signed(rec1[WI_TILE_W]);
    side_in.tile_h  = $signed(rec1[WI_TILE_H]);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      rel2[0] <= 33'(p1_x) - 33'($signed(rec1[WI_ORG_X]));
      rel2[1] <= 33'(p1_y) - 33'($signed(rec1[WI_ORG_Y]));
      rel2[2] <= 33'(p1_z) - 33'($signed(rec1[WI_ORG_Z]));
      axu2[0] <= $signed(rec1[WI_U_X]);
      axu2[1] <= $signed(rec1[WI_U_Y]);
      axu2[2] <= $signed(rec1[WI_U_Z]);
      axv2[0] <= $signed(rec1[WI_V_X]);
      axv2[1] <= $signed(rec1[WI_V_Y]);
      axv2[2] <= $signed(rec1[WI_V_Z]);
      side[2] <= side_in;
    end
    for (int k = 3; k <= 7; k++) begin
      if (rdy[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Stages 3 and 4: axis products, each floored to the fraction, then summed.
  logic signed [U_W-1:0] u4;
  logic signed [U_W-1:0] v4;

  pfta_dot #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (U_W)
  ) u_dot_u (
    .clk     (clk),
    .en_prod (rdy[3]),
    .en_sum  (rdy[4]),
    .rel     (rel2),
    .axis    (axu2),
    .sum     (u4)
  );

  pfta_dot #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (U_W)
  ) u_dot_v (
    .clk     (clk),
    .en_prod (rdy[3]),
    .en_sum  (rdy[4]),
    .rel     (rel2),
    .axis    (axv2),
    .sum     (v4)
  );

  // Stages 5 and 6: scale by the inverse spacing, floor, saturate.
  logic signed [CELL_W-1:0] cell6_u;
  logic signed [CELL_W-1:0] cell6_v;

  pfta_scale #(
    .FRAC_BITS (FRAC_BITS),
    .U_W       (U_W)
  ) u_scale_u (
    .clk      (clk),
    .en_mul   (rdy[5]),
    .en_sat   (rdy[6]),
    .u        (u4),
    .inv      (inv_spacing),
    .cell_pos (cell6_u)
  );

  pfta_scale #(
    .FRAC_BITS (FRAC_BITS),
    .U_W       (U_W)
  ) u_scale_v (
    .clk      (clk),
    .en_mul   (rdy[5]),
    .en_sat   (rdy[6]),
    .u        (v4),
    .inv      (inv_spacing),
    .cell_pos (cell6_v)
  );

  // Stage 7: subtract the start cell and clamp into the tile. The tile size is only
  // meaningful when it is positive; otherwise the query is already marked bad.
  function automatic logic [COL_W-1:0] clamp_cell(
    input logic signed [CELL_W-1:0] c,
    input logic signed [31:0]       start,
    input logic signed [31:0]       size
  );
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] lim;
    d   = DIFF_W'(c) - DIFF_W'(start);
    lim = DIFF_W'(size) - 1;
    if (d < 0) begin
      clamp_cell = '0;
    end else if (d > lim) begin
      clamp_cell = COL_W'(lim);
    end else begin
      clamp_cell = COL_W'(d);
    end
  endfunction

  logic [COL_W-1:0] col7;
  logic [COL_W-1:0] row7;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      col7 <= clamp_cell(cell6_u, side[6].start_u, side[6].tile_w);
      row7 <= clamp_cell(cell6_v, side[6].start_v, side[6].tile_h);
    end
  end

  // Stage 8: offset by the tile position and check against the atlas. A zero atlas
  // size fails the range check on its own.
  logic signed [32:0] x_sum;
  logic signed [32:0] y_sum;
  logic               x_ok;
  logic               y_ok;
  logic               found8;
  logic [15:0]        x8;
  logic [15:0]        y8;

  always_comb begin
    x_sum = 33'(side[7].tile_x) + $signed({2'b00, col7});
    y_sum = 33'(side[7].tile_y) + $signed({2'b00, row7});
    x_ok  = !x_sum[32] && (x_sum < $signed({17'd0, atlas_width}));
    y_ok  = !y_sum[32] && (y_sum < $signed({17'd0, atlas_height}));
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      found8 <= !side[7].bad && x_ok && y_ok;
      x8     <= x_sum[15:0];
      y8     <= y_sum[15:0];
    end
  end

  // Stage 9: row-major address; a word that is not found carries address zero.
  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      found       <= found8;
      texel_index <= found8 ? (32'(y8) * 32'(atlas_width) + 32'(x8)) : '0;
    end
  end

  assign out_valid = v[NSTAGE];

  // No word is taken while the table is still being cleared.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("input accepted during the table clearing pass");

  // Load words never occupy a pipeline slot.
  a_load_no_slot: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_LOAD) |=> !v[1])
    else $error("load word entered the query pipeline");

  // A not-found result always carries a zero address.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> texel_index == '0)
    else $error("not-found result with nonzero texel index");

endmodule
